/* rtl/core/prq_pkg.sv */
// shared types and constants of the priority ready queue
`default_nettype none

package prq_pkg;

    // number of slots in the queue
    localparam int QUEUE_DEPTH = 16;
    // width of the occupancy count, holds zero up to the depth itself
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    localparam int PID_W = 16;
    localparam int PRI_W = 8;
    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    typedef logic [QUEUE_DEPTH-1:0] t_mask;
    typedef logic [OCC_W-1:0] t_occ;
    typedef logic [PID_W-1:0] t_pid;
    typedef logic [PRI_W-1:0] t_pri;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic apply;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/core/prq_datapath.sv */
// slot registers, parallel compare and shift, and result register of the queue
`default_nettype none

module prq_datapath (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire prq_pkg::t_dp_cmd     i_cmd,
    input  wire [prq_pkg::OP_W-1:0]   i_opcode,
    input  wire [prq_pkg::PID_W-1:0]  i_item_pid,
    input  wire [prq_pkg::PRI_W-1:0]  i_item_priority,
    output logic [prq_pkg::ST_W-1:0]  o_status,
    output logic [prq_pkg::PID_W-1:0] o_out_pid,
    output logic [prq_pkg::PRI_W-1:0] o_out_priority
);
    import prq_pkg::*;

    // slot storage, no reset: only slots below occupancy are ever used
    t_pid r_slot_pid [QUEUE_DEPTH];
    t_pri r_slot_pri [QUEUE_DEPTH];
    t_pid n_slot_pid [QUEUE_DEPTH];
    t_pri n_slot_pri [QUEUE_DEPTH];
    t_occ r_occ;
    t_occ n_occ;

    // latched request and compare flags
    t_op   r_op;
    t_pid  r_pid;
    t_pri  r_pri;
    t_mask r_le;
    t_mask r_hit;
    t_mask n_le;
    t_mask n_hit;

    // result register
    t_status r_status;
    t_pid    r_out_pid;
    t_pri    r_out_pri;
    t_status n_status;
    t_pid    n_out_pid;
    t_pri    n_out_pri;

    t_mask w_valid;
    t_mask w_match;
    t_mask w_after;
    logic  w_found;
    logic  w_full;

    // per-slot compare against the incoming word
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_valid[k] = r_occ > OCC_W'(k);
            n_le[k]    = w_valid[k] && (r_slot_pri[k] <= i_item_priority);
            w_match[k] = w_valid[k] && (r_slot_pid[k] == i_item_pid);
        end
        n_hit = '0;
        if (t_op'(i_opcode) == OP_POP) begin
            n_hit[0] = w_valid[0];
        end else if (t_op'(i_opcode) == OP_REMOVE) begin
            // first match from the head: no match in any lower slot
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                n_hit[k] = w_match[k] &&
                    !(|(w_match & t_mask'((t_mask'(1) << k) - t_mask'(1))));
            end
        end
    end

    // slots at or behind the removed one
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_after[k] = |(r_hit & t_mask'((t_mask'(1) << (k + 1)) - t_mask'(1)));
        end
    end

    assign w_found = |r_hit;
    assign w_full  = r_occ == OCC_W'(QUEUE_DEPTH);

    // next slot contents, occupancy and result
    always_comb begin
        n_slot_pid = r_slot_pid;
        n_slot_pri = r_slot_pri;
        n_occ      = r_occ;
        n_status   = ST_OK;
        n_out_pid  = '0;
        n_out_pri  = '0;
        unique case (r_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    // slots past the insert point move one toward the tail
                    if (!r_le[0]) begin
                        n_slot_pid[0] = r_pid;
                        n_slot_pri[0] = r_pri;
                    end
                    for (int k = 1; k < QUEUE_DEPTH; k++) begin
                        if (!r_le[k]) begin
                            if (r_le[k-1]) begin
                                n_slot_pid[k] = r_pid;
                                n_slot_pri[k] = r_pri;
                            end else begin
                                n_slot_pid[k] = r_slot_pid[k-1];
                                n_slot_pri[k] = r_slot_pri[k-1];
                            end
                        end
                    end
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            OP_POP, OP_REMOVE: begin
                if (w_found) begin
                    for (int k = 0; k < QUEUE_DEPTH; k++) begin
                        n_out_pid = n_out_pid | (r_hit[k] ? r_slot_pid[k] : '0);
                        n_out_pri = n_out_pri | (r_hit[k] ? r_slot_pri[k] : '0);
                    end
                    // close the gap toward the head
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                        if (w_after[k]) begin
                            n_slot_pid[k] = r_slot_pid[k+1];
                            n_slot_pri[k] = r_slot_pri[k+1];
                        end
                    end
                    n_occ = r_occ - OCC_W'(1);
                end else begin
                    n_status = ST_NONE;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // request and flag capture at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= t_op'(i_opcode);
            r_pid <= i_item_pid;
            r_pri <= i_item_priority;
            r_le  <= n_le;
            r_hit <= n_hit;
        end
    end

    // slot update and result load
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_slot_pid <= n_slot_pid;
            r_slot_pri <= n_slot_pri;
            r_status   <= n_status;
            r_out_pid  <= n_out_pid;
            r_out_pri  <= n_out_pri;
        end
    end

    // occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.apply) begin
            r_occ <= n_occ;
        end
    end

    assign o_status       = r_status;
    assign o_out_pid      = r_out_pid;
    assign o_out_priority = r_out_pri;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> $onehot0(r_hit))
        else $error("more than one slot selected for removal");
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_op == OP_INSERT && !w_full) |=>
            r_occ == $past(r_occ) + OCC_W'(1))
        else $error("insert did not grow occupancy");
`endif

endmodule

`default_nettype wire

/* rtl/core/prq_ctrl.sv */
// controller state machine of the priority ready queue
`default_nettype none

module prq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    input  wire               i_m_tready,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    output prq_pkg::t_dp_cmd  o_cmd
);
    import prq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_s_tready  = 1'b0;
        o_cmd.latch = 1'b0;
        o_cmd.apply = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.latch = i_s_tvalid;
            end
            S_APPLY: begin
                o_cmd.apply = w_out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // result word valid flag
    always_comb begin
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef SYNTHESIS
    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |-> w_out_free)
        else $error("result overwritten before it was taken");
    a_apply_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> r_out_valid)
        else $error("result word not shown after apply");
    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_APPLY && !o_s_tready))
        else $error("accepted word not followed by apply");
`endif

endmodule

`default_nettype wire

/* rtl/core/priority_ready_queue.sv */
// top level of the priority ready queue
// A sorted queue of up to 16 process entries (16-bit id, 8-bit priority),
// lowest priority value at the head and equal priorities in arrival order.
// Each input word is one request: insert, pop head, remove by id, or no
// operation, and gives exactly one result word (status, removed id and
// priority). A request is handled in a compare step, which checks every
// slot against the word in parallel, then an apply step, which shifts the
// slots and loads the result register. The next word is taken once the
// current one is applied; a result that waits stalls the apply step of the
// following word only, not its accept.
`default_nettype none

module priority_ready_queue (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode [1:0], item_pid [17:2], item_priority [25:18], zero [31:26]
    input  wire  [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status [1:0], out_pid [17:2], out_priority [25:18], zero [31:26]
    output logic [31:0] m_axis_tdata
);
    import prq_pkg::*;

    t_dp_cmd    w_cmd;
    logic [ST_W-1:0]  w_status;
    logic [PID_W-1:0] w_out_pid;
    logic [PRI_W-1:0] w_out_pri;

    // control
    prq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd)
    );

    // slots and result
    prq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (s_axis_tdata[1:0]),
        .i_item_pid      (s_axis_tdata[17:2]),
        .i_item_priority (s_axis_tdata[25:18]),
        .o_status        (w_status),
        .o_out_pid       (w_out_pid),
        .o_out_priority  (w_out_pri)
    );

    // result word packing
    assign m_axis_tdata = {6'd0, w_out_pri, w_out_pid, w_status};

endmodule

`default_nettype wire
